>>> sv/pes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, constants and helpers for the particle Euler step block.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DT_W    = 17;
    localparam int AGE_W   = 31;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z = 2'd3;

    localparam logic [DT_W-1:0]    TIME_STEP_RST = 17'd1092;
    localparam logic signed [31:0] GRAVITY_X_RST = 32'sd0;
    localparam logic signed [31:0] GRAVITY_Y_RST = -32'sd642253;
    localparam logic signed [31:0] GRAVITY_Z_RST = 32'sd0;

    localparam longint Q30_PI      = 64'd3373259426;
    localparam longint Q30_TWO_PI  = 64'd6746518852;
    localparam longint Q30_HALF_PI = 64'd1686629713;
    localparam longint Q30_GAIN    = 64'd652032874;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle;
        logic signed [31:0] spin;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic [AGE_W-1:0]   age;
    } pes_in_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_angle;
        logic [AGE_W-1:0]   new_age;
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
    } pes_out_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle;
        logic [AGE_W-1:0]   age;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
    } pes_mid_t;

    typedef struct packed {
        logic [DT_W-1:0]    time_step;
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic signed [31:0] gravity_z;
    } pes_cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sh80000000)
            r = -32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic longint atan_q30(input int i);
        longint r;
        case (i)
            0:  r = 843314857;
            1:  r = 497837829;
            2:  r = 263043837;
            3:  r = 133525159;
            4:  r = 67021687;
            5:  r = 33543516;
            6:  r = 16775851;
            7:  r = 8388437;
            8:  r = 4194283;
            9:  r = 2097149;
            10: r = 1048576;
            11: r = 524288;
            12: r = 262144;
            13: r = 131072;
            14: r = 65536;
            15: r = 32768;
            16: r = 16384;
            17: r = 8192;
            18: r = 4096;
            19: r = 2048;
            20: r = 1024;
            21: r = 512;
            22: r = 256;
            default: r = 128;
        endcase
        return r;
    endfunction

endpackage

>>> sv/pes_dyn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_dyn
// Four-stage Euler update of velocity, position, angle and age.
// ----------------------------------------------------------------------------
module pes_dyn #(
    parameter int FRAC_BITS = pes_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  pes_pkg::pes_cfg_t cfg,
    input  pes_pkg::pes_in_t  rec,
    output pes_pkg::pes_mid_t mid
);
    import pes_pkg::*;

    localparam int PW = 50;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);

    logic signed [DT_W:0] dts;
    assign dts = {1'b0, cfg.time_step};

    pes_in_t            s1_reg;
    logic signed [PW-1:0] pvx_reg, pvy_reg, pvz_reg, pa_reg;
    logic [31:0]        age_sum_reg;

    pes_mid_t           s2_reg;
    pes_mid_t           s3_reg;
    logic signed [PW-1:0] ppx_reg, ppy_reg, ppz_reg;
    pes_mid_t           s4_reg;

    logic signed [PW-1:0] pvx_next, pvy_next, pvz_next, pa_next;
    logic signed [PW-1:0] ppx_next, ppy_next, ppz_next;
    pes_mid_t           s2_next, s4_next;

    function automatic logic signed [31:0] acc(input logic signed [31:0] base,
                                              input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        q = (p + RND) >>> FRAC_BITS;
        return sat32(64'(base) + 64'(q));
    endfunction

    always_comb
    begin
        pvx_next = cfg.gravity_x * dts;
        pvy_next = cfg.gravity_y * dts;
        pvz_next = cfg.gravity_z * dts;
        pa_next  = rec.spin * dts;
    end

    always_comb
    begin
        s2_next         = '0;
        s2_next.vel_x   = acc(s1_reg.vel_x, pvx_reg);
        s2_next.vel_y   = acc(s1_reg.vel_y, pvy_reg);
        s2_next.vel_z   = acc(s1_reg.vel_z, pvz_reg);
        s2_next.pos_x   = s1_reg.pos_x;
        s2_next.pos_y   = s1_reg.pos_y;
        s2_next.pos_z   = s1_reg.pos_z;
        s2_next.angle   = acc(s1_reg.angle, pa_reg);
        s2_next.age     = age_sum_reg[AGE_W] ? {AGE_W{1'b1}} : age_sum_reg[AGE_W-1:0];
        s2_next.scale_x = s1_reg.scale_x;
        s2_next.scale_y = s1_reg.scale_y;
    end

    always_comb
    begin
        ppx_next = s2_reg.vel_x * dts;
        ppy_next = s2_reg.vel_y * dts;
        ppz_next = s2_reg.vel_z * dts;
    end

    always_comb
    begin
        s4_next       = s3_reg;
        s4_next.pos_x = acc(s3_reg.pos_x, ppx_reg);
        s4_next.pos_y = acc(s3_reg.pos_y, ppy_reg);
        s4_next.pos_z = acc(s3_reg.pos_z, ppz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= rec;
            pvx_reg     <= pvx_next;
            pvy_reg     <= pvy_next;
            pvz_reg     <= pvz_next;
            pa_reg      <= pa_next;
            age_sum_reg <= {1'b0, rec.age} + 32'(cfg.time_step);
            s2_reg      <= s2_next;
            s3_reg      <= s2_reg;
            ppx_reg     <= ppx_next;
            ppy_reg     <= ppy_next;
            ppz_reg     <= ppz_next;
            s4_reg      <= s4_next;
        end
    end

    assign mid = s4_reg;

endmodule

>>> sv/pes_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_sincos
// Angle reduction by restoring steps, pipelined CORDIC, and the scaled
// rotation products of the world matrix.
// ----------------------------------------------------------------------------
module pes_sincos #(
    parameter int FRAC_BITS    = pes_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = pes_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  pes_pkg::pes_mid_t mid,
    output pes_pkg::pes_out_t res
);
    import pes_pkg::*;

    localparam int SH  = 30 - FRAC_BITS;
    localparam int AW  = 62 - FRAC_BITS;
    localparam int QB  = 59 - FRAC_BITS;
    localparam int CW  = 34 + QB;
    localparam int RW  = 36;
    localparam int XW  = 34;
    localparam int N   = CORDIC_STEPS;
    localparam int LAT = QB + N + 7;

    localparam int ST_MUL = QB + N + 5;

    localparam logic [CW-1:0]        TWO_PI_C = CW'(Q30_TWO_PI);
    localparam logic signed [RW-1:0] PI_R     = RW'(Q30_PI);
    localparam logic signed [RW-1:0] TWO_PI_R = RW'(Q30_TWO_PI);
    localparam logic signed [RW-1:0] HPI_R    = RW'(Q30_HALF_PI);
    localparam logic signed [63:0]   RND30    = 64'sd1 <<< 29;

    pes_mid_t car_reg [0:LAT-2];

    logic [AW-1:0] rem_reg [0:QB];
    logic          neg_reg [0:QB];

    logic signed [RW-1:0] r1_reg, r2_reg, r3_reg;
    logic                 flip3_reg;

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic signed [RW-1:0] z_reg [0:N];
    logic                 flip_reg [0:N];

    logic signed [31:0] cs_reg, sn_reg, nsn_reg;
    logic signed [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    pes_out_t           res_reg;

    logic signed [AW-1:0] a_ext;
    assign a_ext = AW'(mid.angle) <<< SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_reg[0] <= mid;
            neg_reg[0] <= mid.angle[31];
            rem_reg[0] <= mid.angle[31] ? -a_ext : a_ext;
        end
    end

    for (genvar k = 1; k < LAT - 1; k++)
    begin : g_car
        always_ff @(posedge clk)
        begin
            if (en)
                car_reg[k] <= car_reg[k-1];
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_red
        localparam int B = QB - j;
        logic [CW-1:0] trial;
        logic          ge;
        assign trial = TWO_PI_C << B;
        assign ge    = CW'(rem_reg[j-1]) >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[j] <= neg_reg[j-1];
                rem_reg[j] <= ge ? rem_reg[j-1] - AW'(trial) : rem_reg[j-1];
            end
        end
    end

    logic signed [RW-1:0] r0;
    assign r0 = $signed({3'b000, rem_reg[QB][32:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= neg_reg[QB] ? -r0 : r0;

            if (r1_reg > PI_R)
                r2_reg <= r1_reg - TWO_PI_R;
            else if (r1_reg < -PI_R)
                r2_reg <= r1_reg + TWO_PI_R;
            else
                r2_reg <= r1_reg;

            if (r2_reg > HPI_R)
            begin
                r3_reg    <= r2_reg - PI_R;
                flip3_reg <= 1'b1;
            end
            else if (r2_reg < -HPI_R)
            begin
                r3_reg    <= r2_reg + PI_R;
                flip3_reg <= 1'b1;
            end
            else
            begin
                r3_reg    <= r2_reg;
                flip3_reg <= 1'b0;
            end
        end
    end

    assign x_reg[0]    = XW'(Q30_GAIN);
    assign y_reg[0]    = '0;
    assign z_reg[0]    = r3_reg;
    assign flip_reg[0] = flip3_reg;

    for (genvar k = 1; k <= N; k++)
    begin : g_cordic
        localparam logic signed [RW-1:0] ATAN_K = RW'(atan_q30(k - 1));
        logic signed [XW-1:0] dx, dy;
        assign dx = y_reg[k-1] >>> (k - 1);
        assign dy = x_reg[k-1] >>> (k - 1);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[k] <= flip_reg[k-1];
                if (!z_reg[k-1][RW-1])
                begin
                    x_reg[k] <= x_reg[k-1] - dx;
                    y_reg[k] <= y_reg[k-1] + dy;
                    z_reg[k] <= z_reg[k-1] - ATAN_K;
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] + dx;
                    y_reg[k] <= y_reg[k-1] - dy;
                    z_reg[k] <= z_reg[k-1] + ATAN_K;
                end
            end
        end
    end

    logic signed [31:0] xc, yc;
    assign xc = x_reg[N][31:0];
    assign yc = y_reg[N][31:0];

    pes_mid_t cm, cr;
    assign cm = car_reg[ST_MUL - 1];
    assign cr = car_reg[LAT - 2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg  <= flip_reg[N] ? -xc : xc;
            sn_reg  <= flip_reg[N] ? -yc : yc;
            nsn_reg <= flip_reg[N] ? yc : -yc;

            p00_reg <= cm.scale_x * cs_reg;
            p01_reg <= cm.scale_x * sn_reg;
            p10_reg <= cm.scale_y * nsn_reg;
            p11_reg <= cm.scale_y * cs_reg;

            res_reg.new_vel_x <= cr.vel_x;
            res_reg.new_vel_y <= cr.vel_y;
            res_reg.new_vel_z <= cr.vel_z;
            res_reg.new_pos_x <= cr.pos_x;
            res_reg.new_pos_y <= cr.pos_y;
            res_reg.new_pos_z <= cr.pos_z;
            res_reg.new_angle <= cr.angle;
            res_reg.new_age   <= cr.age;
            res_reg.m00       <= sat32((p00_reg + RND30) >>> 30);
            res_reg.m01       <= sat32((p01_reg + RND30) >>> 30);
            res_reg.m10       <= sat32((p10_reg + RND30) >>> 30);
            res_reg.m11       <= sat32((p11_reg + RND30) >>> 30);
        end
    end

    assign res = res_reg;

endmodule

>>> sv/particle_euler_step_srt.sv
`timescale 1ns / 1ps
// Throughput: one transfer per cycle unless a held result_stall freezes the
// pipeline; the angle reduction runs one quotient bit per stage and the CORDIC
// one step per stage.
// Reset clears the valid bits and loads the register defaults
// (dt 1/60 s, gravity 0, -9.8, 0).
// ----------------------------------------------------------------------------
// particle_euler_step_srt
// Streaming Euler step of a particle record with scaled z rotation matrix.
// ----------------------------------------------------------------------------
module particle_euler_step_srt #(
    parameter int FRAC_BITS    = pes_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = pes_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pes_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  pes_pkg::pes_in_t                  item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output pes_pkg::pes_out_t                 result
);
    import pes_pkg::*;

    localparam int LAT = 4 + (59 - FRAC_BITS) + CORDIC_STEPS + 7;

    pes_cfg_t cfg_reg;
    logic [LAT-1:0] vld_reg;
    logic en;
    pes_mid_t mid;

    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign item_stall   = !en;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step <= TIME_STEP_RST;
            cfg_reg.gravity_x <= GRAVITY_X_RST;
            cfg_reg.gravity_y <= GRAVITY_Y_RST;
            cfg_reg.gravity_z <= GRAVITY_Z_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP: cfg_reg.time_step <= cfg_data[DT_W-1:0];
                REG_GRAVITY_X: cfg_reg.gravity_x <= cfg_data;
                REG_GRAVITY_Y: cfg_reg.gravity_y <= cfg_data;
                REG_GRAVITY_Z: cfg_reg.gravity_z <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], item_valid};
    end

    pes_dyn #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dyn (
        .clk (clk),
        .en  (en),
        .cfg (cfg_reg),
        .rec (item),
        .mid (mid)
    );

    pes_sincos #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_sincos (
        .clk (clk),
        .en  (en),
        .mid (mid),
        .res (result)
    );

endmodule

>>> tb/sv/particle_euler_step_srt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_step_srt_tb
// Streams particle records through the Euler step block under random source
// gaps and sink stalls, predicts every advanced record and matrix row in the
// testbench, and compares each whole result transfer with its prediction in order.
// ----------------------------------------------------------------------------
module particle_euler_step_srt_tb;
    import pes_pkg::*;

    localparam int FB = 16;
    localparam int STEPS = 16;
    localparam int DRAIN = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    pes_in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    pes_out_t result;

    particle_euler_step_srt dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item_valid(item_valid), .item_stall(item_stall),
        .item(item), .result_valid(result_valid), .result_stall(result_stall),
        .result(result)
    );

    always #5 clk = ~clk;

    longint dt_val;
    longint grav_x, grav_y, grav_z;
    pes_in_t pending_records[$];
    pes_out_t expected_steps[$];
    int fail_count = 0;
    int sent_count = 0;
    int recv_count = 0;
    int config_count = 0;
    longint cycle_count = 0;
    bit hold_sink = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return floor_shift(v + (longint'(1) <<< (s - 1)), s);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint advance(longint base, longint rate);
        return clamp32(base + round_shift(rate * dt_val, FB));
    endfunction

    function automatic longint arctan_entry(int i);
        longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
        return t[i];
    endfunction

    function automatic void rotate(input longint ang, output longint sn,
                                   output longint cs);
        longint r, x, y, nx, dx, dy;
        bit flip;
        r = (ang * (longint'(1) <<< (30 - FB))) % Q30_TWO_PI;
        x = Q30_GAIN;
        y = 0;
        flip = 1'b0;
        if (r > Q30_PI)
            r -= Q30_TWO_PI;
        else if (r < -Q30_PI)
            r += Q30_TWO_PI;
        if (r > Q30_HALF_PI)
        begin
            r -= Q30_PI;
            flip = 1'b1;
        end
        else if (r < -Q30_HALF_PI)
        begin
            r += Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                nx = x - dx;
                y = y + dy;
                r -= arctan_entry(i);
            end
            else
            begin
                nx = x + dx;
                y = y - dy;
                r += arctan_entry(i);
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic pes_out_t step_particle(pes_in_t p);
        pes_out_t o;
        longint vx, vy, vz, ang, agev, sn, cs, sxs, sys;
        vx = advance(longint'(p.vel_x), grav_x);
        vy = advance(longint'(p.vel_y), grav_y);
        vz = advance(longint'(p.vel_z), grav_z);
        ang = advance(longint'(p.angle), longint'(p.spin));
        agev = longint'({1'b0, p.age}) + dt_val;
        if (agev > 64'sd2147483647)
            agev = 64'sd2147483647;
        rotate(ang, sn, cs);
        sxs = longint'(p.scale_x);
        sys = longint'(p.scale_y);
        o.new_vel_x = vx[31:0];
        o.new_vel_y = vy[31:0];
        o.new_vel_z = vz[31:0];
        o.new_pos_x = 32'(advance(longint'(p.pos_x), vx));
        o.new_pos_y = 32'(advance(longint'(p.pos_y), vy));
        o.new_pos_z = 32'(advance(longint'(p.pos_z), vz));
        o.new_angle = ang[31:0];
        o.new_age = agev[30:0];
        o.m00 = 32'(clamp32(round_shift(sxs * cs, 30)));
        o.m01 = 32'(clamp32(round_shift(sxs * sn, 30)));
        o.m10 = 32'(clamp32(round_shift(-(sys * sn), 30)));
        o.m11 = 32'(clamp32(round_shift(sys * cs, 30)));
        return o;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 400000)) - 200000);
            3: return 32'(int'($urandom_range(0, 4000)) - 2000);
            default: return $urandom;
        endcase
    endfunction

    function automatic pes_in_t rand_record();
        pes_in_t p;
        p.vel_x = rand_word();
        p.vel_y = rand_word();
        p.vel_z = rand_word();
        p.pos_x = rand_word();
        p.pos_y = rand_word();
        p.pos_z = rand_word();
        p.angle = rand_word();
        p.spin = rand_word();
        p.scale_x = rand_word();
        p.scale_y = rand_word();
        p.scale_z = $urandom;
        if ($urandom_range(0, 3) == 0)
            p.age = 31'h7FFFFFFF - 31'($urandom_range(0, 70000));
        else
            p.age = 31'($urandom);
        return p;
    endfunction

    function automatic pes_in_t flat_record(logic [31:0] w, logic [30:0] a);
        pes_in_t p;
        p = {{11{w}}, a};
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TIME_STEP: dt_val = longint'(val[DT_W-1:0]);
            REG_GRAVITY_X: grav_x = longint'(signed'(val));
            REG_GRAVITY_Y: grav_y = longint'(signed'(val));
            default: grav_z = longint'(signed'(val));
        endcase
        config_count++;
    endtask

    task automatic drain_pipeline();
        while (pending_records.size() != 0 || expected_steps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // source side
    int src_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_steps = {expected_steps, step_particle(item)};
                void'(pending_records.pop_front());
                sent_count++;
                src_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            end
            if (!(item_valid && item_stall))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_records.size() > 0)
                begin
                    item_valid <= 1'b1;
                    item <= pending_records[0];
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // sink side
    int sink_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (result_valid && !result_stall)
            begin
                recv_count++;
                if (expected_steps.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    pes_out_t e;
                    e = expected_steps.pop_front();
                    if (e !== result)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, result);
                        fail_count++;
                    end
                end
                sink_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            end
            if (hold_sink)
                result_stall <= 1'b1;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] edge_words[6] = '{32'h7FFFFFFF, 32'h80000000, 32'h0,
                                       32'hFFFFFFFF, 32'h00010000, 32'h0003243F};
        dt_val = longint'(TIME_STEP_RST);
        grav_x = 0;
        grav_y = longint'(GRAVITY_Y_RST);
        grav_z = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (edge_words[i])
            pending_records = {pending_records, flat_record(edge_words[i], 31'h7FFFFFFF)};
        pending_records = {pending_records, flat_record(32'h0, 31'h0)};
        for (int i = 0; i < 12; i++)
        begin
            pes_in_t p;
            p = rand_record();
            p.angle = 32'(int'($urandom_range(0, 12)) * 51472 - 308832);
            pending_records = {pending_records, p};
        end
        drain_pipeline();
        // long sink hold-off while the source keeps offering
        hold_sink = 1'b1;
        for (int i = 0; i < 150; i++)
            pending_records = {pending_records, rand_record()};
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
        drain_pipeline();
        for (int phase = 0; phase < 6; phase++)
        begin
            repeat (DRAIN) @(posedge clk);
            case (phase)
                0:
                begin
                    write_reg(REG_TIME_STEP, 32'd65536);
                    write_reg(REG_GRAVITY_X, 32'h7FFFFFFF);
                    write_reg(REG_GRAVITY_Y, 32'h80000000);
                    write_reg(REG_GRAVITY_Z, 32'hFFFF0000);
                end
                1: write_reg(REG_TIME_STEP, 32'd0);
                2:
                begin
                    write_reg(REG_TIME_STEP, 32'h1FFFF);
                    write_reg(REG_GRAVITY_Z, 32'h80000000);
                end
                3:
                begin
                    write_reg(REG_TIME_STEP, 32'($urandom_range(1, 65536)));
                    write_reg(REG_GRAVITY_X, rand_word());
                    write_reg(REG_GRAVITY_Y, rand_word());
                    write_reg(REG_GRAVITY_Z, rand_word());
                end
                4: write_reg(REG_TIME_STEP, 32'd1);
                default:
                begin
                    write_reg(REG_TIME_STEP, 32'd1092);
                    write_reg(REG_GRAVITY_X, 32'h0);
                    write_reg(REG_GRAVITY_Y, 32'hFFF633B3);
                    write_reg(REG_GRAVITY_Z, 32'h0);
                end
            endcase
            for (int i = 0; i < 290; i++)
                pending_records = {pending_records, rand_record()};
            drain_pipeline();
        end
        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d record transfers, %0d results, %0d register writes.",
                 sent_count, recv_count, config_count);
        $display("Directed extremes, a long sink hold-off and six dt/gravity settings.");
        if (fail_count == 0 && expected_steps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
